[hdl/modular_exponentiation_core_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the modular exponentiation core
// Shared property wrappers on clk with the asynchronous reset masked.
// ---------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_CORE_DEFINES_SVH
`define MODULAR_EXPONENTIATION_CORE_DEFINES_SVH

// same-cycle implication
`define MEXP_ASSERT_IMPL(label, ant, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MEXP_ASSERT_NEXT(label, ant, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error(msg);

`endif

[hdl/mexp_pkg.sv]
// ---------------------------------------------------------------------------
// mexp_pkg
// Widths, register map, microcode formats and control store of the
// modular exponentiation core.
// ---------------------------------------------------------------------------
`default_nettype none

package mexp_pkg;

	localparam int WORD_BITS = 32;
	localparam int CNT_BITS  = $clog2(WORD_BITS);
	localparam int STEP_BITS = 4;
	localparam int ADDR_BITS = 3;

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [CNT_BITS-1:0]  cnt_t;
	typedef logic [STEP_BITS-1:0] step_t;

	localparam cnt_t  CNT_MAX  = cnt_t'(WORD_BITS - 1);
	localparam step_t STEP_ONE = step_t'(1);

	// register map, selected by paddr[2]
	localparam logic REG_EXPONENT = 1'b0;
	localparam logic REG_MODULUS  = 1'b1;

	localparam word_t EXPONENT_RESET = word_t'(139967);
	localparam word_t MODULUS_RESET  = word_t'(45293789);

	typedef enum logic [3:0] {
		OP_NOP,
		OP_INIT,
		OP_X_R,
		OP_X_R_NEXT,
		OP_LOAD_AX,
		OP_LOAD_XX,
		OP_ACC_R,
		OP_DBL,
		OP_ADD,
		OP_OUT_ACC,
		OP_OUT_ZERO
	} op_t;

	typedef enum logic [3:0] {
		J_NEXT,
		J_NOSTART,
		J_MSMALL,
		J_CALL,
		J_EBIT0,
		J_BNZ,
		J_NOTLAST,
		J_ALWAYS,
		J_RETURN
	} jmp_t;

	typedef struct packed {
		op_t   op;
		jmp_t  jmp;
		step_t target;
	} uword_t;

	typedef struct packed {
		logic start;
		logic msmall;
		logic ebit;
		logic bnz;
		logic notlast;
	} status_t;

	typedef struct packed {
		op_t  op;
		logic busy;
	} ctrl_t;

	// program entry points
	localparam step_t ST_IDLE = step_t'(0);
	localparam step_t ST_TEST = step_t'(4);
	localparam step_t ST_ZERO = step_t'(10);
	localparam step_t ST_MUL  = step_t'(11);

	// Control store. The modular multiply r = a*b mod m is a subroutine at
	// ST_MUL: one double step and one conditional add step per bit of b.
	function automatic uword_t ucode_rom(input step_t addr);
		uword_t w;
		case (addr)
			step_t'(0):  w = '{OP_INIT,     J_NOSTART, ST_IDLE};
			step_t'(1):  w = '{OP_NOP,      J_MSMALL,  ST_ZERO};
			step_t'(2):  w = '{OP_NOP,      J_CALL,    ST_MUL};
			step_t'(3):  w = '{OP_X_R,      J_NEXT,    ST_IDLE};
			step_t'(4):  w = '{OP_NOP,      J_EBIT0,   step_t'(7)};
			step_t'(5):  w = '{OP_LOAD_AX,  J_CALL,    ST_MUL};
			step_t'(6):  w = '{OP_ACC_R,    J_NEXT,    ST_IDLE};
			step_t'(7):  w = '{OP_LOAD_XX,  J_CALL,    ST_MUL};
			step_t'(8):  w = '{OP_X_R_NEXT, J_NOTLAST, ST_TEST};
			step_t'(9):  w = '{OP_OUT_ACC,  J_ALWAYS,  ST_IDLE};
			step_t'(10): w = '{OP_OUT_ZERO, J_ALWAYS,  ST_IDLE};
			step_t'(11): w = '{OP_DBL,      J_NEXT,    ST_IDLE};
			step_t'(12): w = '{OP_ADD,      J_BNZ,     ST_MUL};
			step_t'(13): w = '{OP_NOP,      J_RETURN,  ST_IDLE};
			default:     w = '{OP_NOP,      J_ALWAYS,  ST_IDLE};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

[hdl/mexp_seq.sv]
// ---------------------------------------------------------------------------
// mexp_seq
// Microcode sequencer: step counter, control store, conditional jumps and
// a one-level return address for the multiply subroutine.
// ---------------------------------------------------------------------------
`default_nettype none

module mexp_seq (
	input  wire                logic clk,
	input  wire                logic arst_n,
	input  wire mexp_pkg::status_t status,
	output mexp_pkg::ctrl_t    ctrl
);
	import mexp_pkg::*;

	step_t  step_q;
	step_t  ret_q;
	step_t  step_nx;
	step_t  step_inc;
	uword_t uw;

	assign uw       = ucode_rom(step_q);
	assign step_inc = step_q + STEP_ONE;

	always_comb begin
		case (uw.jmp)
			J_NEXT:    step_nx = step_inc;
			J_NOSTART: step_nx = status.start ? step_inc : uw.target;
			J_MSMALL:  step_nx = status.msmall ? uw.target : step_inc;
			J_CALL:    step_nx = uw.target;
			J_EBIT0:   step_nx = status.ebit ? step_inc : uw.target;
			J_BNZ:     step_nx = status.bnz ? uw.target : step_inc;
			J_NOTLAST: step_nx = status.notlast ? uw.target : step_inc;
			J_ALWAYS:  step_nx = uw.target;
			J_RETURN:  step_nx = ret_q;
			default:   step_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
			ret_q  <= ST_IDLE;
		end else begin
			step_q <= step_nx;
			// save the caller's next step
			if (uw.jmp == J_CALL) begin
				ret_q <= step_inc;
			end
		end
	end

	assign ctrl.op   = uw.op;
	assign ctrl.busy = (step_q != ST_IDLE);

endmodule

`default_nettype wire

[hdl/modular_exponentiation_core.sv]
// ---------------------------------------------------------------------------
// modular_exponentiation_core
// power_result = base ^ exponent mod modulus, right-to-left square and
// multiply on a microcoded datapath with bit-serial modular multiplies.
// ---------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy stays high
// until the result is ready. The result appears on power_result for one
// cycle with done high and must be captured then: the block does not wait.
// Every modular multiply handles each bit of the multiplier as a double step
// and then a conditional add step, each one 33-bit add and compare. With a
// modulus below two a request returns 0. Write exponent (address 0) and
// modulus (address 4) only while busy is low.
// ---------------------------------------------------------------------------
`default_nettype none

module modular_exponentiation_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic [mexp_pkg::WORD_BITS-1:0]  base,
	output logic                                 done,
	output logic [mexp_pkg::WORD_BITS-1:0]       power_result,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [mexp_pkg::ADDR_BITS-1:0]  paddr,
	input  wire logic [31:0]                     pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready
);
	import mexp_pkg::*;

	word_t   exp_q, mod_q;
	word_t   acc_q, x_q, a_q, b_q, r_q, result_q;
	cnt_t    bcnt_q, ecnt_q;
	logic    done_q;
	status_t status;
	ctrl_t   ctrl;

	logic                 cfg_wr;
	word_t                addend;
	logic [WORD_BITS:0]   sum;
	logic [WORD_BITS+1:0] diff;
	word_t                red;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_MODULUS) ? mod_q : exp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q <= EXPONENT_RESET;
			mod_q <= MODULUS_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_EXPONENT) begin
				exp_q <= pwdata;
			end else begin
				mod_q <= pwdata;
			end
		end
	end

	mexp_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	assign status.start   = start;
	assign status.msmall  = (mod_q[WORD_BITS-1:1] == '0);
	assign status.ebit    = exp_q[ecnt_q];
	assign status.bnz     = (bcnt_q != '0);
	assign status.notlast = (ecnt_q != CNT_MAX);

	// shared modular adder: r + addend, drop m once if not below it
	assign addend = (ctrl.op == OP_DBL) ? r_q : a_q;
	assign sum    = {1'b0, r_q} + {1'b0, addend};
	assign diff   = {1'b0, sum} - {2'b00, mod_q};
	assign red    = diff[WORD_BITS+1] ? sum[WORD_BITS-1:0] : diff[WORD_BITS-1:0];

	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_INIT: begin
				// x = base mod m, formed as 1 * base mod m
				acc_q  <= word_t'(1);
				ecnt_q <= '0;
				a_q    <= word_t'(1);
				b_q    <= base;
				r_q    <= '0;
				bcnt_q <= CNT_MAX;
			end
			OP_X_R: begin
				x_q <= r_q;
			end
			OP_X_R_NEXT: begin
				x_q    <= r_q;
				ecnt_q <= ecnt_q + cnt_t'(1);
			end
			OP_LOAD_AX: begin
				a_q    <= acc_q;
				b_q    <= x_q;
				r_q    <= '0;
				bcnt_q <= CNT_MAX;
			end
			OP_LOAD_XX: begin
				a_q    <= x_q;
				b_q    <= x_q;
				r_q    <= '0;
				bcnt_q <= CNT_MAX;
			end
			OP_ACC_R: begin
				acc_q <= r_q;
			end
			OP_DBL: begin
				r_q <= red;
			end
			OP_ADD: begin
				if (b_q[bcnt_q]) begin
					r_q <= red;
				end
				bcnt_q <= bcnt_q - cnt_t'(1);
			end
			OP_OUT_ACC: begin
				result_q <= acc_q;
			end
			OP_OUT_ZERO: begin
				result_q <= '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (ctrl.op == OP_OUT_ACC) || (ctrl.op == OP_OUT_ZERO);
		end
	end

	assign busy         = ctrl.busy;
	assign done         = done_q;
	assign power_result = result_q;

endmodule

`default_nettype wire

[hdl/mexp_checker.sv]
// ---------------------------------------------------------------------------
// mexp_checker
// Port-level checks of request and result timing and of the config port, bound to the core.
// ---------------------------------------------------------------------------
`default_nettype none

`include "modular_exponentiation_core_defines.svh"

module mexp_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done,
	input wire logic psel,
	input wire logic pready
);

	`MEXP_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy low after request")
	`MEXP_ASSERT_NEXT(a_accept_no_done, start && !busy, !done, "result right after request")
	`MEXP_ASSERT_IMPL(a_done_idle, done, !busy, "result while still busy")
	`MEXP_ASSERT_NEXT(a_done_single, done, !done, "result strobe longer than a cycle")
	`MEXP_ASSERT_IMPL(a_pready_high, psel, pready, "config port stalled")

endmodule

bind modular_exponentiation_core mexp_checker u_mexp_checker (.*);

`default_nettype wire

[tb/sv/mexp_checker.sv]
// ---------------------------------------------------------------------------
// mexp_scoreboard
// Watches the request, result and register ports of the modular
// exponentiation core, predicts every power_result and compares it.
// ---------------------------------------------------------------------------
`default_nettype none

module mexp_scoreboard
	import mexp_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic                 busy,
	input  wire word_t                base,
	input  wire logic                 done,
	input  wire word_t                power_result,
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [ADDR_BITS-1:0] paddr,
	input  wire logic [31:0]          pwdata,
	input  wire logic [31:0]          prdata,
	input  wire logic                 pready,
	output int                        error_count,
	output int                        outstanding
);

	word_t exp_shadow;
	word_t mod_shadow;
	word_t pending_powers[$];
	int    errs;

	// right-to-left square and multiply; the 64-bit product cannot overflow
	function automatic word_t pow_mod(input word_t b, input word_t e, input word_t m);
		longint unsigned x;
		longint unsigned acc;
		longint unsigned mm;
		int k;
		if (m < 2)
			return '0;
		mm  = m;
		x   = b % m;
		acc = 1;
		for (k = 0; k < WORD_BITS; k++) begin
			if (e[k])
				acc = (acc * x) % mm;
			x = (x * x) % mm;
		end
		return word_t'(acc);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		word_t want;
		word_t reg_val;
		if (!arst_n) begin
			exp_shadow = EXPONENT_RESET;
			mod_shadow = MODULUS_RESET;
			pending_powers.delete();
			errs = 0;
			error_count <= 0;
			outstanding <= 0;
		end else begin
			// retire the oldest request before queuing a new one
			if (done) begin
				if (pending_powers.size() == 0) begin
					errs++;
					$display("%0t: unexpected result, expected none, actual %h",
						$time, power_result);
				end else begin
					want = pending_powers.pop_front();
					if (power_result !== want) begin
						errs++;
						$display("%0t: power_result mismatch, expected %h, actual %h",
							$time, want, power_result);
					end
				end
			end
			if (start && !busy)
				pending_powers.insert(pending_powers.size(),
					pow_mod(base, exp_shadow, mod_shadow));
			if (psel && penable && pready) begin
				if (pwrite) begin
					if (paddr[2] == REG_EXPONENT)
						exp_shadow = pwdata;
					else
						mod_shadow = pwdata;
				end else begin
					reg_val = (paddr[2] == REG_EXPONENT) ? exp_shadow : mod_shadow;
					if (prdata !== reg_val) begin
						errs++;
						$display("%0t: register readback mismatch, expected %h, actual %h",
							$time, reg_val, prdata);
					end
				end
			end
			error_count <= errs;
			outstanding <= pending_powers.size();
		end
	end

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// ---------------------------------------------------------------------------
// tb
// Drives base requests and register writes into the modular exponentiation
// core over a range of exponent and modulus settings, and gives the verdict.
// ---------------------------------------------------------------------------
`default_nettype none

module tb;
	import mexp_pkg::*;

	localparam int STALL_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 4500;
	localparam int RANDOM_PHASES = 7;
	localparam int REQS_PER_PHASE = 17;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	word_t                base = '0;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [ADDR_BITS-1:0] paddr = '0;
	logic [31:0]          pwdata = '0;
	logic                 busy;
	logic                 done;
	word_t                power_result;
	logic [31:0]          prdata;
	logic                 pready;
	int                   error_count;
	int                   outstanding;
	int                   idle_cycles = 0;
	word_t                cur_mod = MODULUS_RESET;
	logic                 quiet = 1'b0;

	always #4 clk = ~clk;

	modular_exponentiation_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .base(base),
		.done(done), .power_result(power_result), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.pready(pready)
	);

	mexp_scoreboard u_scoreboard (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .base(base),
		.done(done), .power_result(power_result), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.pready(pready), .error_count(error_count), .outstanding(outstanding)
	);

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (psel && penable && pready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	function automatic int next_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 19);
		if (r < 10)
			return 0;
		if (r < 17)
			return $urandom_range(1, 4);
		return $urandom_range(20, 300);
	endfunction

	function automatic word_t pick_base();
		case ($urandom_range(0, 9))
			0: return cur_mod - 1;
			1: return cur_mod + word_t'($urandom_range(0, 3));
			2: return word_t'($urandom_range(0, 3));
			default: return $urandom;
		endcase
	endfunction

	// hold start until the core takes the request; start stays high afterward
	task automatic issue(input word_t b, input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		base  <= b;
		do @(posedge clk); while (busy);
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0 || busy);
	endtask

	task automatic apb_access(input logic wr, input logic sel, input word_t data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {sel, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// write both registers, each followed by a readback
	task automatic set_config(input word_t e, input word_t m);
		drain();
		apb_access(1'b1, REG_EXPONENT, e);
		apb_access(1'b0, REG_EXPONENT, e);
		apb_access(1'b1, REG_MODULUS, m);
		apb_access(1'b0, REG_MODULUS, m);
		cur_mod = m;
	endtask

	initial begin
		word_t e;
		word_t m;
		int ph;
		int n;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: base extremes and bases around the modulus
		issue(32'h0000_0000, next_gap());
		issue(32'h0000_0001, next_gap());
		issue(32'h0000_0002, next_gap());
		issue(MODULUS_RESET - 1, next_gap());
		issue(MODULUS_RESET, next_gap());
		issue(MODULUS_RESET + 1, next_gap());
		issue(32'hFFFF_FFFF, next_gap());
		issue(32'h8000_0000, next_gap());

		// zero exponent gives one
		set_config(32'h0, 32'hFFFF_FFFF);
		issue(32'h0000_0000, next_gap());
		issue(32'hFFFF_FFFF, next_gap());
		issue(32'h0000_0005, next_gap());

		// longest run: every exponent bit set
		set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		issue(32'hFFFF_FFFE, next_gap());
		issue(32'h0000_0003, next_gap());

		// modulus below two gives zero
		set_config(32'h0001_2345, 32'h0);
		issue(32'h0000_0000, next_gap());
		issue(32'hFFFF_FFFF, next_gap());
		set_config(32'h0, 32'h1);
		issue(32'h0000_0007, next_gap());

		// smallest proper modulus
		set_config(32'h1, 32'h2);
		issue(32'h0000_0000, next_gap());
		issue(32'h0000_0001, next_gap());
		issue(32'hFFFF_FFFF, next_gap());

		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			case ($urandom_range(0, 9))
				0:       m = word_t'($urandom_range(0, 1));
				1, 2:    m = word_t'($urandom_range(2, 300));
				3, 4, 5: m = $urandom;
				default: m = $urandom | 32'h8000_0000;
			endcase
			e = ($urandom_range(0, 4) == 0) ? word_t'($urandom_range(0, 15)) : $urandom;
			set_config(e, m);
			quiet = ($urandom_range(0, 3) == 0);
			for (n = 0; n < REQS_PER_PHASE; n++)
				issue(pick_base(), next_gap());
		end

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule

`default_nettype wire
